FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Implication: when cond holds, prop must hold in the same cycle.
`define ASSERT_WHEN(lbl, clk, rst_n, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// Implication: when cond holds, prop must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/mrrp_pkg.sv
`default_nettype none

package mrrp_pkg;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_FUNC  = 3'd2,
		ST_CRC   = 3'd3,
		ST_COUNT = 3'd4
	} status_t;

	localparam logic KIND_VALUE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [7:0]  FN_READ_INPUT  = 8'h04;
	localparam logic [7:0]  FN_WRITE_MULTI = 8'h10;
	localparam logic [15:0] MIN_READ_LEN   = 16'd5;
	localparam logic [15:0] MIN_WRITE_LEN  = 16'd8;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = 2;
	localparam int unsigned FIFO_CW    = 3;

	typedef struct packed {
		logic        kind;
		logic [31:0] value_bits;
		status_t     status;
		logic [7:0]  slave_id;
		logic [15:0] reg_count;
		logic [15:0] start_reg;
		logic [15:0] crc_received;
		logic        last;
	} result_t;

	typedef struct packed {
		logic push_first;
		logic push_second;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic not_empty;
		logic room_for_two;
	} fifo_stat_t;

	// Reflected Modbus CRC-16, one byte.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mrrp_fifo.sv
`default_nettype none

module mrrp_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mrrp_pkg::fifo_ctl_t  ctl,
	input  wire mrrp_pkg::result_t    din_first,
	input  wire mrrp_pkg::result_t    din_second,
	output mrrp_pkg::result_t         dout,
	output mrrp_pkg::fifo_stat_t      stat
);

	mrrp_pkg::result_t               mem_q [mrrp_pkg::FIFO_DEPTH];
	logic [mrrp_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [mrrp_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [mrrp_pkg::FIFO_CW-1:0]    cnt_q;
	logic [mrrp_pkg::FIFO_CW-1:0]    push_n;
	logic [mrrp_pkg::FIFO_AW-1:0]    wr_ptr_nx;

	assign push_n    = mrrp_pkg::FIFO_CW'(ctl.push_first) + mrrp_pkg::FIFO_CW'(ctl.push_second);
	assign wr_ptr_nx = wr_ptr_q + mrrp_pkg::FIFO_AW'(1);

	assign dout              = mem_q[rd_ptr_q];
	assign stat.not_empty    = cnt_q != '0;
	assign stat.room_for_two = cnt_q <= mrrp_pkg::FIFO_CW'(mrrp_pkg::FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (ctl.push_first) begin
			mem_q[wr_ptr_q] <= din_first;
		end
		if (ctl.push_second) begin
			mem_q[wr_ptr_nx] <= din_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[mrrp_pkg::FIFO_AW-1:0];
			if (ctl.pop) begin
				rd_ptr_q <= rd_ptr_q + mrrp_pkg::FIFO_AW'(1);
			end
			cnt_q <= cnt_q + push_n - mrrp_pkg::FIFO_CW'(ctl.pop);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/modbus_rtu_response_parser_core.sv
// An item is written to the result queue when its byte is accepted and shows on the output at the queue head.
// Throughput: one byte per cycle while in_ready is high; each byte yields zero, one or two
// items, which drain one per cycle while out_ready is high from a four-entry result queue.
// in_ready drops while fewer than two queue slots are free.
// Reset: arst_n clears the frame state and the queue; the running CRC resets to 0xFFFF.
`default_nettype none

module modbus_rtu_response_parser_core #(
	parameter int unsigned MAX_FRAME_BYTES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	input  wire logic        expect_write,
	input  wire logic [15:0] expected_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             result_kind,
	output logic [31:0]      value_bits,
	output logic [2:0]       status,
	output logic [7:0]       slave_id,
	output logic [15:0]      reg_count,
	output logic [15:0]      start_reg,
	output logic [15:0]      crc_received,
	output logic             last_result
);

	localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1);

	logic [PW-1:0] pos_q;
	logic          write_q;
	logic [15:0]   count_match_q;
	logic [7:0]    slave_q;
	logic          fmatch_q;
	logic [7:0]    decl_q;
	logic [23:0]   partial_q;
	logic [15:0]   start_q;
	logic [15:0]   count_q;
	logic [15:0]   crc_q;
	logic [15:0]   tail_q;

	logic [PW-1:0] pos_d;
	logic          write_d;
	logic [15:0]   count_match_d;
	logic [7:0]    slave_d;
	logic          fmatch_d;
	logic [7:0]    decl_d;
	logic [23:0]   partial_d;
	logic [15:0]   start_d;
	logic [15:0]   count_d;
	logic [15:0]   crc_d;
	logic [15:0]   tail_d;

	logic          in_fire;
	logic          p_zero;
	logic [15:0]   pos16;
	logic [PW-1:0] pos_off;
	logic [15:0]   grp16;
	logic          value_hit;
	logic          too_short;

	mrrp_pkg::result_t    val_rec;
	mrrp_pkg::result_t    stat_rec;
	mrrp_pkg::result_t    head;
	mrrp_pkg::fifo_ctl_t  ctl;
	mrrp_pkg::fifo_stat_t fstat;

	assign in_fire = in_valid && in_ready;
	assign p_zero  = pos_q == '0;
	assign pos16   = 16'(pos_q);
	assign pos_off = pos_q - PW'(6);
	assign grp16   = 16'(pos_off) >> 2;

	// Frame state update for the byte at the input.
	always_comb begin
		write_d       = p_zero ? expect_write : write_q;
		count_match_d = p_zero ? expected_count : count_match_q;
		slave_d       = p_zero ? data_byte : slave_q;
		crc_d         = mrrp_pkg::crc16_byte(p_zero ? mrrp_pkg::CRC_INIT : crc_q, data_byte);
		fmatch_d      = p_zero ? 1'b0 : fmatch_q;
		decl_d        = p_zero ? 8'h00 : decl_q;
		start_d       = p_zero ? 16'h0000 : start_q;
		count_d       = p_zero ? 16'h0000 : count_q;
		partial_d     = {(p_zero ? 16'h0000 : partial_q[15:0]), data_byte};
		tail_d        = {(p_zero ? 8'h00 : tail_q[7:0]), data_byte};
		if (pos16 == 16'd1) begin
			fmatch_d = data_byte == (write_q ? mrrp_pkg::FN_WRITE_MULTI
					: mrrp_pkg::FN_READ_INPUT);
		end
		if (pos16 == 16'd2) begin
			decl_d = data_byte;
		end
		if (pos16 == 16'd2 || pos16 == 16'd3) begin
			start_d = {start_q[7:0], data_byte};
		end
		if (pos16 == 16'd4 || pos16 == 16'd5) begin
			count_d = {count_q[7:0], data_byte};
		end
		if (frame_end) begin
			pos_d = '0;
		end else if (pos16 < 16'(MAX_FRAME_BYTES)) begin
			pos_d = pos_q + PW'(1);
		end else begin
			pos_d = pos_q;
		end
	end

	// In a matching read reply, a value completes on every fourth data byte within the declared count.
	assign value_hit = !write_q && fmatch_q && pos16 >= 16'd6
			&& pos16 < 16'(MAX_FRAME_BYTES) && pos_q[1:0] == 2'd2
			&& grp16 < 16'(decl_q[7:2]);

	assign too_short = (pos16 + 16'd1) < (write_d ? mrrp_pkg::MIN_WRITE_LEN
			: mrrp_pkg::MIN_READ_LEN);

	always_comb begin
		val_rec            = '0;
		val_rec.kind       = mrrp_pkg::KIND_VALUE;
		val_rec.value_bits = {partial_q[7:0], data_byte, partial_q[23:16], partial_q[15:8]};
		val_rec.status     = mrrp_pkg::ST_OK;
	end

	always_comb begin
		stat_rec        = '0;
		stat_rec.kind   = mrrp_pkg::KIND_STATUS;
		stat_rec.last   = 1'b1;
		stat_rec.status = mrrp_pkg::ST_OK;
		if (too_short) begin
			stat_rec.status = mrrp_pkg::ST_SHORT;
		end else if (!fmatch_d) begin
			stat_rec.status   = mrrp_pkg::ST_FUNC;
			stat_rec.slave_id = slave_d;
		end else begin
			stat_rec.slave_id     = slave_d;
			stat_rec.reg_count    = write_d ? count_d : {9'd0, decl_d[7:1]};
			stat_rec.start_reg    = write_d ? start_d : 16'h0000;
			stat_rec.crc_received = {tail_d[7:0], tail_d[15:8]};
			if (crc_d != 16'h0000) begin
				stat_rec.status = mrrp_pkg::ST_CRC;
			end else if (write_d && count_d != count_match_d) begin
				stat_rec.status = mrrp_pkg::ST_COUNT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			write_q       <= 1'b0;
			count_match_q <= '0;
			slave_q       <= '0;
			fmatch_q      <= 1'b0;
			decl_q        <= '0;
			partial_q     <= '0;
			start_q       <= '0;
			count_q       <= '0;
			crc_q         <= mrrp_pkg::CRC_INIT;
			tail_q        <= '0;
		end else if (in_fire) begin
			pos_q         <= pos_d;
			write_q       <= write_d;
			count_match_q <= count_match_d;
			slave_q       <= slave_d;
			fmatch_q      <= fmatch_d;
			decl_q        <= decl_d;
			partial_q     <= partial_d;
			start_q       <= start_d;
			count_q       <= count_d;
			crc_q         <= crc_d;
			tail_q        <= tail_d;
		end
	end

	// The value item goes first when a byte yields both.
	assign ctl.push_first  = in_fire && (value_hit || frame_end);
	assign ctl.push_second = in_fire && value_hit && frame_end;
	assign ctl.pop         = out_valid && out_ready;

	mrrp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.din_first  (value_hit ? val_rec : stat_rec),
		.din_second (stat_rec),
		.dout       (head),
		.stat       (fstat)
	);

	assign in_ready     = fstat.room_for_two;
	assign out_valid    = fstat.not_empty;
	assign result_kind  = head.kind;
	assign value_bits   = head.value_bits;
	assign status       = head.status;
	assign slave_id     = head.slave_id;
	assign reg_count    = head.reg_count;
	assign start_reg    = head.start_reg;
	assign crc_received = head.crc_received;
	assign last_result  = head.last;

endmodule

`default_nettype wire

FILE: hw/rtl/mrrp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module mrrp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [7:0]  data_byte,
	input wire logic        frame_end,
	input wire logic        expect_write,
	input wire logic [15:0] expected_count,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        result_kind,
	input wire logic [31:0] value_bits,
	input wire logic [2:0]  status,
	input wire logic [7:0]  slave_id,
	input wire logic [15:0] reg_count,
	input wire logic [15:0] start_reg,
	input wire logic [15:0] crc_received,
	input wire logic        last_result
);

	logic short_item;
	logic value_item;

	assign value_item = out_valid && result_kind == mrrp_pkg::KIND_VALUE;
	assign short_item = out_valid && result_kind == mrrp_pkg::KIND_STATUS
			&& status == mrrp_pkg::ST_SHORT;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_WHEN(a_last_on_status, clk, arst_n, out_valid, last_result == result_kind)
	`ASSERT_WHEN(a_value_clean, clk, arst_n, value_item, status == mrrp_pkg::ST_OK && slave_id == 8'h00 && reg_count == 16'h0000 && crc_received == 16'h0000)
	`ASSERT_WHEN(a_short_clean, clk, arst_n, short_item, value_bits == 32'h0 && slave_id == 8'h00 && start_reg == 16'h0000)
	`ASSERT_NEXT(a_accept_shows, clk, arst_n, in_valid && in_ready && frame_end, out_valid)

endmodule

bind modbus_rtu_response_parser_core mrrp_checker u_mrrp_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_PERIOD   = 20;
	localparam int FRAME_LIMIT  = 256;
	localparam int RUN_LIMIT_NS = 10_000_000;

	typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;
	typedef enum int {FAULT_CRC, FAULT_FUNC, FAULT_COUNT, FAULT_SHORT} fault_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte      = 8'h00;
	logic        frame_end      = 1'b0;
	logic        expect_write   = 1'b0;
	logic [15:0] expected_count = 16'h0000;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic        result_kind;
	logic [31:0] value_bits;
	logic [2:0]  status;
	logic [7:0]  slave_id;
	logic [15:0] reg_count;
	logic [15:0] start_reg;
	logic [15:0] crc_received;
	logic        last_result;

	// parser shadow state
	logic [8:0]  rx_pos        = '0;
	logic        rx_write      = 1'b0;
	logic [15:0] rx_want_count = '0;
	logic [7:0]  rx_slave      = '0;
	logic        rx_fn_ok      = 1'b0;
	logic [7:0]  rx_decl       = '0;
	logic [23:0] rx_window     = '0;
	logic [15:0] rx_start      = '0;
	logic [15:0] rx_count      = '0;
	logic [15:0] rx_crc        = mrrp_pkg::CRC_INIT;
	logic [15:0] rx_tail       = '0;

	mrrp_pkg::result_t pending_results[$];
	logic [7:0]        frame_buf[$];

	idle_mode_t  send_mode   = IDLE_NONE;
	idle_mode_t  take_mode   = IDLE_NONE;
	int unsigned take_wait   = 0;
	int unsigned hold_cycles = 0;

	int unsigned bytes_sent   = 0;
	int unsigned frames_sent  = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count   = 0;

	modbus_rtu_response_parser_core #(
		.MAX_FRAME_BYTES(FRAME_LIMIT)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.frame_end     (frame_end),
		.expect_write  (expect_write),
		.expected_count(expected_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.value_bits    (value_bits),
		.status        (status),
		.slave_id      (slave_id),
		.reg_count     (reg_count),
		.start_reg     (start_reg),
		.crc_received  (crc_received),
		.last_result   (last_result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned draw_wait(input idle_mode_t mode);
		case (mode)
			IDLE_LIGHT: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
			IDLE_HEAVY: return $urandom_range(0, 17);
			default:    return 0;
		endcase
	endfunction

	function automatic void shuffle_idle();
		send_mode = idle_mode_t'($urandom_range(0, 2));
		take_mode = idle_mode_t'($urandom_range(0, 2));
	endfunction

	// Reflected CRC-16, feeding one data bit into the LSB per shift.
	function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ mrrp_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	function automatic mrrp_pkg::result_t make_result(input logic kind,
			input logic [31:0] v, input mrrp_pkg::status_t st, input logic [7:0] sl,
			input logic [15:0] cnt, input logic [15:0] start, input logic [15:0] crc);
		mrrp_pkg::result_t r;
		r.kind         = kind;
		r.value_bits   = v;
		r.status       = st;
		r.slave_id     = sl;
		r.reg_count    = cnt;
		r.start_reg    = start;
		r.crc_received = crc;
		r.last         = kind;
		return r;
	endfunction

	function automatic void queue_result(input mrrp_pkg::result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void append_byte(input logic [7:0] b);
		frame_buf.insert(frame_buf.size(), b);
	endfunction

	// Advance the shadow parser by one byte and queue the results it owes.
	function automatic void parse_reply_byte(input logic [7:0] b, input logic fe,
			input logic wr, input logic [15:0] cnt);
		logic [15:0]       frame_len;
		logic [15:0]       min_len;
		mrrp_pkg::status_t st;
		if (rx_pos == 0) begin
			rx_write      = wr;
			rx_want_count = cnt;
			rx_slave      = b;
			rx_fn_ok      = 1'b0;
			rx_decl       = '0;
			rx_window     = '0;
			rx_start      = '0;
			rx_count      = '0;
			rx_tail       = '0;
			rx_crc        = crc_fold(mrrp_pkg::CRC_INIT, b);
		end else begin
			rx_crc = crc_fold(rx_crc, b);
		end
		case (rx_pos)
			9'd1: rx_fn_ok = (b == (rx_write ? mrrp_pkg::FN_WRITE_MULTI
					: mrrp_pkg::FN_READ_INPUT));
			9'd2: begin
				rx_decl  = b;
				rx_start = {rx_start[7:0], b};
			end
			9'd3: rx_start = {rx_start[7:0], b};
			9'd4, 9'd5: rx_count = {rx_count[7:0], b};
			default: ;
		endcase
		// a group closes at positions 6, 10, 14, ... while within the declared bytes
		if (!rx_write && rx_fn_ok && rx_pos >= 9'd6 && rx_pos < FRAME_LIMIT &&
				rx_pos[1:0] == 2'd2 && ((rx_pos - 9'd6) >> 2) < (rx_decl >> 2)) begin
			queue_result(make_result(mrrp_pkg::KIND_VALUE,
				{rx_window[7:0], b, rx_window[23:16], rx_window[15:8]},
				mrrp_pkg::ST_OK, 8'h00, 16'h0, 16'h0, 16'h0));
		end
		rx_window = {rx_window[15:0], b};
		rx_tail   = {rx_tail[7:0], b};
		if (fe) begin
			frame_len = 16'(rx_pos) + 16'd1;
			min_len   = rx_write ? mrrp_pkg::MIN_WRITE_LEN : mrrp_pkg::MIN_READ_LEN;
			if (frame_len < min_len) begin
				queue_result(make_result(mrrp_pkg::KIND_STATUS, 32'h0, mrrp_pkg::ST_SHORT,
					8'h00, 16'h0, 16'h0, 16'h0));
			end else if (!rx_fn_ok) begin
				queue_result(make_result(mrrp_pkg::KIND_STATUS, 32'h0, mrrp_pkg::ST_FUNC,
					rx_slave, 16'h0, 16'h0, 16'h0));
			end else begin
				if (rx_crc != 16'h0) begin
					st = mrrp_pkg::ST_CRC;
				end else if (rx_write && rx_count != rx_want_count) begin
					st = mrrp_pkg::ST_COUNT;
				end else begin
					st = mrrp_pkg::ST_OK;
				end
				queue_result(make_result(mrrp_pkg::KIND_STATUS, 32'h0, st, rx_slave,
					rx_write ? rx_count : {9'h000, rx_decl[7:1]},
					rx_write ? rx_start : 16'h0, {rx_tail[7:0], rx_tail[15:8]}));
			end
			rx_pos = '0;
		end else if (rx_pos < FRAME_LIMIT) begin
			rx_pos = rx_pos + 9'd1;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the byte is accepted, with valid low.
	task automatic send_byte(input logic [7:0] b, input logic fe, input logic wr,
			input logic [15:0] cnt);
		int unsigned gap;
		gap = draw_wait(send_mode);
		repeat (gap) @(negedge clk);
		data_byte      = b;
		frame_end      = fe;
		expect_write   = wr;
		expected_count = cnt;
		in_valid       = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		parse_reply_byte(b, fe, wr, cnt);
		bytes_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic void start_frame(input logic [7:0] sl, input logic [7:0] fn);
		frame_buf.delete();
		append_byte(sl);
		append_byte(fn);
	endfunction

	function automatic void push_random(input int n);
		for (int i = 0; i < n; i++) begin
			append_byte(8'($urandom));
		end
	endfunction

	function automatic void seal_frame();
		logic [15:0] acc;
		acc = mrrp_pkg::CRC_INIT;
		foreach (frame_buf[i]) acc = crc_fold(acc, frame_buf[i]);
		append_byte(acc[7:0]);
		append_byte(acc[15:8]);
	endfunction

	function automatic void build_read(input int decl, input int ndata);
		start_frame(8'($urandom), mrrp_pkg::FN_READ_INPUT);
		append_byte(8'(decl));
		push_random(ndata);
		seal_frame();
	endfunction

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void build_write(input logic [15:0] start, input logic [15:0] cnt,
			input int pad);
		start_frame(8'($urandom), mrrp_pkg::FN_WRITE_MULTI);
		append_byte(start[15:8]);
		append_byte(start[7:0]);
		append_byte(cnt[15:8]);
		append_byte(cnt[7:0]);
		push_random(pad);
		seal_frame();
	endfunction

	// Later bytes carry random mode and count, which the block must ignore.
	task automatic transmit_frame(input logic wr, input logic [15:0] cnt);
		for (int i = 0; i < frame_buf.size(); i++) begin
			if (i == 0) begin
				send_byte(frame_buf[i], frame_buf.size() == 1, wr, cnt);
			end else begin
				send_byte(frame_buf[i], i == frame_buf.size() - 1, 1'($urandom),
					16'($urandom));
			end
		end
		frames_sent++;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_directed_basics();
		send_mode = IDLE_NONE;
		take_mode = IDLE_LIGHT;
		start_frame(8'hFF, mrrp_pkg::FN_READ_INPUT);
		append_byte(8'd4);
		append_byte(8'h00);
		append_byte(8'hFF);
		append_byte(8'hA5);
		append_byte(8'h5A);
		seal_frame();
		transmit_frame(1'b0, 16'h0000);
		start_frame(8'h00, mrrp_pkg::FN_WRITE_MULTI);
		push_random(0);
		repeat (4) append_byte(8'hFF);
		seal_frame();
		transmit_frame(1'b1, 16'hFFFF);
		// a frame that ends on its first byte
		frame_buf.delete();
		append_byte(8'h55);
		transmit_frame(1'b0, 16'h0000);
		start_frame(8'h7E, 8'h03);
		append_byte(8'h00);
		seal_frame();
		transmit_frame(1'b0, 16'h0000);
	endtask

	task automatic test_read_frames();
		int decl;
		for (int f = 0; f < 16; f++) begin
			shuffle_idle();
			decl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 21) : 4 * $urandom_range(0, 5);
			build_read(decl, decl);
			transmit_frame(1'b0, 16'($urandom));
		end
	endtask

	task automatic test_write_frames();
		logic [15:0] cnt;
		for (int f = 0; f < 30; f++) begin
			shuffle_idle();
			cnt = pick16();
			build_write(pick16(), cnt, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
			transmit_frame(1'b1, cnt);
		end
	endtask

	task automatic test_error_frames();
		fault_t      fault;
		logic        wr;
		logic [15:0] cnt;
		logic [7:0]  fn;
		int          keep;
		for (int f = 0; f < 24; f++) begin
			shuffle_idle();
			fault = fault_t'($urandom_range(0, 3));
			wr    = 1'($urandom);
			cnt   = pick16();
			if (wr) begin
				build_write(pick16(), cnt, 0);
			end else begin
				build_read(4 * $urandom_range(0, 3), 0);
				// refill the data to match the declared count
				keep = frame_buf[2];
				frame_buf = frame_buf[0:2];
				push_random(keep);
				seal_frame();
			end
			case (fault)
				FAULT_CRC: begin
					keep = $urandom_range(0, frame_buf.size() - 1);
					frame_buf[keep] = frame_buf[keep] ^ 8'(1 << $urandom_range(0, 7));
				end
				FAULT_FUNC: begin
					fn = 8'($urandom);
					if (fn == (wr ? mrrp_pkg::FN_WRITE_MULTI : mrrp_pkg::FN_READ_INPUT)) begin
						fn = wr ? mrrp_pkg::FN_READ_INPUT : mrrp_pkg::FN_WRITE_MULTI;
					end
					frame_buf[1] = fn;
					frame_buf = frame_buf[0:frame_buf.size() - 3];
					seal_frame();
				end
				FAULT_COUNT: begin
					wr = 1'b1;
					build_write(pick16(), cnt, 0);
					cnt = cnt ^ 16'($urandom_range(1, 65535));
				end
				default: begin
					keep = $urandom_range(1, wr ? 7 : 4);
					while (frame_buf.size() > keep) frame_buf.pop_back();
				end
			endcase
			transmit_frame(wr, cnt);
		end
	endtask

	// Declared byte count can run past the data, so CRC bytes may land in value groups.
	task automatic test_values_past_end();
		int decl;
		shuffle_idle();
		build_read(4, 2);
		transmit_frame(1'b0, 16'h0000);
		for (int f = 0; f < 7; f++) begin
			shuffle_idle();
			decl = $urandom_range(4, 40);
			build_read(decl, $urandom_range(0, decl));
			transmit_frame(1'b0, 16'($urandom));
		end
	endtask

	task automatic test_overlong_frame();
		send_mode = IDLE_LIGHT;
		take_mode = IDLE_LIGHT;
		build_read(255, 257);
		transmit_frame(1'b0, 16'h0000);
	endtask

	// Receiver holds off while the sender streams values back to back.
	task automatic test_output_backpressure();
		send_mode   = IDLE_NONE;
		take_mode   = IDLE_NONE;
		hold_cycles = 300;
		for (int f = 0; f < 2; f++) begin
			build_read(32, 32);
			transmit_frame(1'b0, 16'h0000);
		end
	endtask

	task automatic test_random_noise();
		for (int n = 0; n < 100; n++) begin
			if (n % 20 == 0) begin
				shuffle_idle();
			end
			send_byte(8'($urandom), (n == 99) || ($urandom_range(0, 5) == 0),
				1'($urandom), 16'($urandom));
		end
	endtask

	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			out_ready = 1'b0;
			hold_cycles--;
		end else if (take_wait != 0) begin
			out_ready = 1'b0;
			take_wait--;
		end else begin
			out_ready = 1'b1;
		end
	end

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		mrrp_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: result expected none actual kind %0d value %0h status %0d",
					$time, result_kind, value_bits, status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("value_bits", want.value_bits, value_bits);
				check_field("status", want.status, status);
				check_field("slave_id", want.slave_id, slave_id);
				check_field("reg_count", want.reg_count, reg_count);
				check_field("start_reg", want.start_reg, start_reg);
				check_field("crc_received", want.crc_received, crc_received);
				check_field("last_result", want.last, last_result);
			end
			take_wait = draw_wait(take_mode);
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_basics();
		wait_drained();
		test_read_frames();
		wait_drained();
		test_write_frames();
		wait_drained();
		test_error_frames();
		wait_drained();
		test_values_past_end();
		wait_drained();
		test_overlong_frame();
		wait_drained();
		test_output_backpressure();
		wait_drained();
		test_random_noise();
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes in %0d frames plus noise; checked %0d results.",
			bytes_sent, frames_sent, results_seen);
		$display("Covered reads, writes, faults, values past frame end, overlong frame, stalls.");
		if (fail_count == 0) begin
			$display("modbus_rtu_response_parser_core: match");
		end else begin
			$display("modbus_rtu_response_parser_core: mismatch");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Timed out with %0d results outstanding.", pending_results.size());
		$display("modbus_rtu_response_parser_core: mismatch");
		$finish;
	end

endmodule

FILE: modbus_rtu_response_parser_core.f
+incdir+hw/rtl
hw/rtl/mrrp_pkg.sv
hw/rtl/mrrp_fifo.sv
hw/rtl/modbus_rtu_response_parser_core.sv
hw/rtl/mrrp_checker.sv
tb/sv/tb_top.sv
